/* hdl/sorted_interval_membership_macros.svh */
// Assertion macros for the sorted interval membership block.
// Each use samples on the rising edge of clk and is off while rst_n is low.
`ifndef SORTED_INTERVAL_MEMBERSHIP_MACROS_SVH
`define SORTED_INTERVAL_MEMBERSHIP_MACROS_SVH

// Same-cycle implication.
`define SIM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SIM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sim_pkg.sv */
`default_nettype none

package sim_pkg;

    localparam int MAX_RANGES = 256;
    localparam int ADDR_W     = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int DATA_W     = 32;
    localparam int ENTRY_W    = 2 * DATA_W;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] range_low;
        logic signed [DATA_W-1:0] range_high;
        logic signed [DATA_W-1:0] query_value;
    } item_t;

    typedef struct packed {
        logic inside_res;
        logic status;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic rd_shift;
        logic step_query;
        logic wr_shift;
        logic wr_new;
        logic pend_load;
        logic pend_inside;
        logic pend_status;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_query;
        logic full;
        logic idx_zero;
        logic empty_window;
        logic hit;
        logic go_low;
        logic go_high;
        logic start_le;
    } sts_t;

endpackage

`default_nettype wire

/* hdl/sim_ram.sv */
`default_nettype none

module sim_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/sim_datapath.sv */
`default_nettype none

module sim_datapath (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sim_pkg::item_t  item,
    input  wire sim_pkg::cmd_t   cmd,
    output sim_pkg::sts_t        sts,
    output sim_pkg::result_t     result
);

    sim_pkg::item_t             item_reg;
    logic [sim_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [sim_pkg::CNT_W-1:0]  lo_reg, lo_next;
    logic [sim_pkg::CNT_W-1:0]  hi_reg, hi_next;
    logic [sim_pkg::CNT_W-1:0]  idx_reg, idx_next;
    logic                       pend_inside_reg, pend_status_reg;
    sim_pkg::result_t           result_reg;

    logic [sim_pkg::CNT_W-1:0]   mid;
    logic [sim_pkg::CNT_W-1:0]   idx_dec;
    logic [sim_pkg::ADDR_W-1:0]  raddr;
    logic [sim_pkg::ADDR_W-1:0]  waddr;
    logic [sim_pkg::ENTRY_W-1:0] wdata;
    logic [sim_pkg::ENTRY_W-1:0] rdata;
    logic                        we;
    logic signed [sim_pkg::DATA_W-1:0] ent_start, ent_end;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_dec = idx_reg - 1'b1;
    assign raddr   = cmd.rd_shift ? idx_dec[sim_pkg::ADDR_W-1:0] : mid[sim_pkg::ADDR_W-1:0];
    assign waddr   = idx_reg[sim_pkg::ADDR_W-1:0];
    assign we      = cmd.wr_shift | cmd.wr_new;
    // Move the probed entry up one slot, or drop the new range in
    assign wdata   = cmd.wr_new ? {item_reg.range_low, item_reg.range_high} : rdata;

    sim_ram #(
        .WIDTH (sim_pkg::ENTRY_W),
        .DEPTH (sim_pkg::MAX_RANGES)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign ent_start = $signed(rdata[sim_pkg::ENTRY_W-1:sim_pkg::DATA_W]);
    assign ent_end   = $signed(rdata[sim_pkg::DATA_W-1:0]);

    always_comb
    begin
        sts.is_query     = (item_reg.func == sim_pkg::FUNC_QUERY);
        sts.full         = (count_reg == sim_pkg::CNT_W'(sim_pkg::MAX_RANGES));
        sts.idx_zero     = (idx_reg == '0);
        sts.empty_window = (lo_reg >= hi_reg);
        sts.hit          = (item_reg.query_value >= ent_start)
                           && (item_reg.query_value <= ent_end);
        sts.go_low       = (item_reg.query_value < ent_end);
        sts.go_high      = (item_reg.query_value > ent_end);
        sts.start_le     = (ent_start <= item_reg.range_low);
    end

    always_comb
    begin
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        if (cmd.load)
        begin
            lo_next  = '0;
            hi_next  = count_reg;
            idx_next = count_reg;
        end
        if (cmd.step_query)
        begin
            if (sts.go_low)
            begin
                hi_next = mid;
            end
            else
            begin
                lo_next = mid + 1'b1;
            end
        end
        if (cmd.wr_shift)
        begin
            idx_next = idx_dec;
        end
        if (cmd.wr_new)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        idx_reg <= idx_next;
        if (cmd.pend_load)
        begin
            pend_inside_reg <= cmd.pend_inside;
            pend_status_reg <= cmd.pend_status;
        end
        if (cmd.out_load)
        begin
            result_reg.inside_res <= pend_inside_reg;
            result_reg.status     <= pend_status_reg;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

/* hdl/sim_ctrl.sv */
`default_nettype none

module sim_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    output logic                result_valid,
    input  wire logic           result_stall,
    input  wire sim_pkg::sts_t  sts,
    output sim_pkg::cmd_t       cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_QUERY_CMP,
        ST_INSERT_CMP,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;

    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg && result_stall;
        cmd               = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (sts.is_query)
                begin
                    if (sts.empty_window)
                    begin
                        cmd.pend_load = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_QUERY_CMP;
                    end
                end
                else if (sts.full)
                begin
                    cmd.pend_load   = 1'b1;
                    cmd.pend_status = 1'b1;
                    state_next      = ST_DONE;
                end
                else if (sts.idx_zero)
                begin
                    cmd.wr_new    = 1'b1;
                    cmd.pend_load = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.rd_shift = 1'b1;
                    state_next   = ST_INSERT_CMP;
                end
            end
            ST_QUERY_CMP:
            begin
                if (sts.hit)
                begin
                    cmd.pend_load   = 1'b1;
                    cmd.pend_inside = 1'b1;
                    state_next      = ST_DONE;
                end
                else if (sts.go_low || sts.go_high)
                begin
                    cmd.step_query = 1'b1;
                    state_next     = ST_DISPATCH;
                end
                else
                begin
                    // inverted range probed at its end: stop outside
                    cmd.pend_load = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_INSERT_CMP:
            begin
                if (sts.start_le)
                begin
                    cmd.wr_new    = 1'b1;
                    cmd.pend_load = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.wr_shift = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!result_valid_reg || !result_stall)
                begin
                    cmd.out_load      = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

/* hdl/sorted_interval_membership.sv */
// Sorted interval membership table.
// Item channel (item_valid, item_stall, item): func 0 inserts [range_low, range_high]
// at its place by start, func 1 tests query_value against the stored ranges.
// Result channel (result_valid, result_stall, result): one beat per item; inside_res
// for a query, status 1 for an insert into a full table.
// One item is worked at a time; item_stall is high from acceptance until the
// result is loaded into the output register.
// Query: each probe is one registered read of the range table plus one compare;
// the query ends when a probe hits or stops on an inverted range, or when the
// window empties (at most 9 probes at 256 entries).
// Insert: entries above the new range's place each move up one slot, and the new
// range may land in slot 0; the table RAM has one read and one write port, so
// each moved entry is read in ST_DISPATCH and then written in ST_INSERT_CMP.
// A full-table insert or an empty-table query goes from dispatch straight to done.
// The result sits in an output register; while result_stall holds it, the next
// item is still accepted and worked, and only its handoff waits.
// Reset empties the table (count to zero); table contents are not cleared.
`default_nettype none

`include "sorted_interval_membership_macros.svh"

module sorted_interval_membership (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire sim_pkg::item_t    item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output sim_pkg::result_t       result
);

    sim_pkg::cmd_t cmd;
    sim_pkg::sts_t sts;

    sim_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    sim_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

    `SIM_ASSERT_NEXT(a_busy, item_valid && !item_stall, item_stall, "no stall after accept")
    `SIM_ASSERT_NOW(a_no_write_full, cmd.wr_new || cmd.wr_shift, !sts.full, "write while full")
    `SIM_ASSERT_NOW(a_out_free, cmd.out_load, !result_valid || !result_stall, "overwrite")
    `SIM_ASSERT_NOW(a_single_flag, result_valid, !(result.inside_res && result.status), "two flags")

endmodule

`default_nettype wire
